// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the block's top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define KPD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked in the same cycle
`define KPD_ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

`endif

// ----- rtl/core/kpd_pkg.sv -----
// Package for the packet deframer: codes, constants and the command type
package kpd_pkg;

  localparam logic [7:0] SohMark   = 8'd1;
  localparam logic [7:0] LenBase   = 8'd35;
  localparam logic [7:0] CharBase  = 8'd32;
  localparam logic [6:0] MaxData   = 7'd94;
  localparam logic [7:0] TypeSinit = 8'd83;
  localparam logic [6:0] QuoteLo   = 7'd63;
  localparam logic [6:0] QuoteHi   = 7'd95;
  localparam logic [7:0] Bit6Mask  = 8'd64;
  localparam logic [7:0] PrefixRst = 8'd35;

  localparam logic KindData    = 1'b0;
  localparam logic KindSummary = 1'b1;

  localparam logic [1:0] StGood     = 2'd0;
  localparam logic [1:0] StBadCheck = 2'd1;
  localparam logic [1:0] StShort    = 2'd2;

  localparam int CmdDepth = 2;
  localparam int CmdPtrW  = (CmdDepth > 1) ? $clog2(CmdDepth) : 1;
  localparam int CmdCntW  = $clog2(CmdDepth + 1);

  localparam logic RegCtlPrefix = 1'b0;

  typedef enum logic [1:0] {
    OP_DATA,
    OP_SHORT,
    OP_CHECK
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] byte_v;
    logic       quoted;
    logic       fresh;
    logic [7:0] sum;
    logic [7:0] ptype;
    logic [5:0] pseq;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- rtl/core/kpd_front.sv -----
// Front end: framing state machine that classifies each byte into commands
module kpd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          byte_valid_i,
  input  logic [7:0]    rx_byte_i,
  input  logic [7:0]    ctl_prefix_i,
  output logic          cmd_push_o,
  output kpd_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEN,
    PH_SEQ,
    PH_TYPE,
    PH_DATA,
    PH_CHECK,
    PH_SEQ_SHORT,
    PH_TYPE_SHORT
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] sum_q, sum_d;
  logic [6:0] left_q, left_d;
  logic [7:0] type_q, type_d;
  logic [5:0] seq_q, seq_d;
  logic       quote_q, quote_d;
  logic       emitted_q, emitted_d;

  logic [7:0] sum_add;
  logic [7:0] len_off;

  assign sum_add = sum_q + rx_byte_i;
  assign len_off = rx_byte_i - kpd_pkg::LenBase;

  always_comb begin
    phase_d   = phase_q;
    sum_d     = sum_q;
    left_d    = left_q;
    type_d    = type_q;
    seq_d     = seq_q;
    quote_d   = quote_q;
    emitted_d = emitted_q;
    cmd_push_o    = 1'b0;
    cmd_o.op      = kpd_pkg::OP_DATA;
    cmd_o.byte_v  = rx_byte_i;
    cmd_o.quoted  = quote_q;
    cmd_o.fresh   = !emitted_q;
    cmd_o.sum     = sum_q;
    cmd_o.ptype   = type_q;
    cmd_o.pseq    = seq_q;
    if (byte_valid_i) begin
      case (phase_q)
        PH_IDLE: begin
          if (rx_byte_i == kpd_pkg::SohMark) begin
            sum_d   = 8'd0;
            phase_d = PH_LEN;
          end
        end
        PH_LEN: begin
          sum_d = rx_byte_i;
          if (rx_byte_i < kpd_pkg::LenBase) begin
            phase_d = PH_SEQ_SHORT;
          end else begin
            left_d  = (len_off > {1'b0, kpd_pkg::MaxData}) ? kpd_pkg::MaxData : len_off[6:0];
            phase_d = PH_SEQ;
          end
        end
        PH_SEQ, PH_SEQ_SHORT: begin
          sum_d   = sum_add;
          seq_d   = 6'(rx_byte_i - kpd_pkg::CharBase);
          phase_d = (phase_q == PH_SEQ) ? PH_TYPE : PH_TYPE_SHORT;
        end
        PH_TYPE: begin
          sum_d     = sum_add;
          type_d    = rx_byte_i;
          quote_d   = 1'b0;
          emitted_d = 1'b0;
          phase_d   = (left_q != 7'd0) ? PH_DATA : PH_CHECK;
        end
        PH_TYPE_SHORT: begin
          sum_d        = sum_add;
          type_d       = rx_byte_i;
          quote_d      = 1'b0;
          emitted_d    = 1'b0;
          phase_d      = PH_IDLE;
          cmd_push_o   = 1'b1;
          cmd_o.op     = kpd_pkg::OP_SHORT;
          cmd_o.ptype  = rx_byte_i;
          cmd_o.fresh  = 1'b1;
        end
        PH_DATA: begin
          sum_d  = sum_add;
          left_d = left_q - 7'd1;
          if (type_q != kpd_pkg::TypeSinit && !quote_q && rx_byte_i == ctl_prefix_i) begin
            quote_d = 1'b1;
          end else begin
            quote_d    = 1'b0;
            emitted_d  = 1'b1;
            cmd_push_o = 1'b1;
            cmd_o.op   = kpd_pkg::OP_DATA;
          end
          if (left_q == 7'd1) begin
            phase_d = PH_CHECK;
          end
        end
        PH_CHECK: begin
          phase_d    = PH_IDLE;
          cmd_push_o = 1'b1;
          cmd_o.op   = kpd_pkg::OP_CHECK;
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      sum_q     <= 8'd0;
      left_q    <= 7'd0;
      type_q    <= 8'd0;
      seq_q     <= 6'd0;
      quote_q   <= 1'b0;
      emitted_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      sum_q     <= sum_d;
      left_q    <= left_d;
      type_q    <= type_d;
      seq_q     <= seq_d;
      quote_q   <= quote_d;
      emitted_q <= emitted_d;
    end
  end

endmodule

// ----- rtl/core/kpd_cmd_queue.sv -----
// Short command queue between the front end and the back end
module kpd_cmd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  kpd_pkg::cmd_t     push_cmd_i,
  input  logic              pop_i,
  output kpd_pkg::cmd_t     pop_cmd_o,
  output kpd_pkg::q_stat_t  stat_o
);

  kpd_pkg::cmd_t                 mem_q [kpd_pkg::CmdDepth];
  logic [kpd_pkg::CmdPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [kpd_pkg::CmdPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [kpd_pkg::CmdCntW-1:0]   cnt_q, cnt_d;
  logic                          do_push;
  logic                          do_pop;

  localparam logic [kpd_pkg::CmdPtrW-1:0] PtrLast = kpd_pkg::CmdPtrW'(kpd_pkg::CmdDepth - 1);

  assign stat_o.full  = (cnt_q == kpd_pkg::CmdCntW'(kpd_pkg::CmdDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign pop_cmd_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ----- rtl/core/kpd_back.sv -----
// Back end: unquoting, counting, checksum check and the result register
module kpd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  kpd_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  input  logic          res_pop_i,
  output logic          res_valid_o,
  output logic          out_kind_o,
  output logic [7:0]    data_byte_o,
  output logic [7:0]    pkt_type_o,
  output logic [5:0]    pkt_seq_o,
  output logic [1:0]    status_o,
  output logic [6:0]    data_count_o
);

  logic       valid_q, valid_d;
  logic [6:0] count_q, count_d;
  logic       kind_q, kind_d;
  logic [7:0] data_q, data_d;
  logic [7:0] type_q, type_d;
  logic [5:0] seq_q, seq_d;
  logic [1:0] stat_q, stat_d;
  logic [6:0] dcnt_q, dcnt_d;

  logic [6:0] base;
  logic [6:0] low7;
  logic       flip;
  logic [5:0] chk;
  logic       chk_ok;

  assign cmd_pop_o = cmd_valid_i && (!valid_q || res_pop_i);
  assign base      = cmd_i.fresh ? 7'd0 : count_q;
  assign low7      = cmd_i.byte_v[6:0];
  assign flip      = cmd_i.quoted && low7 >= kpd_pkg::QuoteLo && low7 <= kpd_pkg::QuoteHi;
  assign chk       = cmd_i.sum[5:0] + {4'd0, cmd_i.sum[7:6]};
  assign chk_ok    = (cmd_i.byte_v >= kpd_pkg::CharBase) &&
                     ((cmd_i.byte_v - kpd_pkg::CharBase) == {2'd0, chk});

  always_comb begin
    valid_d = valid_q;
    count_d = count_q;
    kind_d  = kind_q;
    data_d  = data_q;
    type_d  = type_q;
    seq_d   = seq_q;
    stat_d  = stat_q;
    dcnt_d  = dcnt_q;
    if (res_pop_i) begin
      valid_d = 1'b0;
    end
    if (cmd_pop_o) begin
      valid_d = 1'b1;
      type_d  = cmd_i.ptype;
      seq_d   = cmd_i.pseq;
      case (cmd_i.op)
        kpd_pkg::OP_DATA: begin
          kind_d  = kpd_pkg::KindData;
          data_d  = flip ? (cmd_i.byte_v ^ kpd_pkg::Bit6Mask) : cmd_i.byte_v;
          stat_d  = kpd_pkg::StGood;
          dcnt_d  = base + 7'd1;
          count_d = base + 7'd1;
        end
        kpd_pkg::OP_SHORT: begin
          kind_d = kpd_pkg::KindSummary;
          data_d = 8'd0;
          stat_d = kpd_pkg::StShort;
          dcnt_d = 7'd0;
        end
        kpd_pkg::OP_CHECK: begin
          kind_d = kpd_pkg::KindSummary;
          data_d = 8'd0;
          stat_d = chk_ok ? kpd_pkg::StGood : kpd_pkg::StBadCheck;
          dcnt_d = base;
        end
        default: begin
          kind_d = kpd_pkg::KindSummary;
          data_d = 8'd0;
          stat_d = kpd_pkg::StBadCheck;
          dcnt_d = base;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      count_q <= 7'd0;
    end else begin
      valid_q <= valid_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    data_q <= data_d;
    type_q <= type_d;
    seq_q  <= seq_d;
    stat_q <= stat_d;
    dcnt_q <= dcnt_d;
  end

  assign res_valid_o  = valid_q;
  assign out_kind_o   = kind_q;
  assign data_byte_o  = data_q;
  assign pkt_type_o   = type_q;
  assign pkt_seq_o    = seq_q;
  assign status_o     = stat_q;
  assign data_count_o = dcnt_q;

endmodule

// ----- rtl/core/kermit_packet_deframer.sv -----
// Top level of the packet deframer: configuration register, front, queue, back
//
// Input channel: a received byte on rx_byte_i is taken at a clock edge with
// push high and full low. One byte can be taken every cycle while full is low.
// Result channel: the oldest result waits on the result ports while empty is
// low and leaves at an edge with pop high. A data result carries one decoded
// byte and its running count; a summary result carries type, sequence number
// and status at the end of a packet, or right after TYPE for a short length.
// Path: a command caused by a byte is written into the command queue at the
// edge at which that byte is taken, then moves into the result register.
// Throughput: one byte per cycle while full is low, set by the framer.
// Stalling: while pop stays low, results collect in a two-entry command queue
// behind the result register; full rises once that queue is filled, and the
// input is held off until the receiver takes a result.
// Reset: the framer hunts for the start mark, all queues are empty and the
// quote prefix is '#'. The APB register at address 0 holds the prefix. The user
// must write it only while no packet is in progress; the block does not enforce it.
`include "assert_macros.svh"

module kermit_packet_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic        out_kind_o,
  output logic [7:0]  data_byte_o,
  output logic [7:0]  pkt_type_o,
  output logic [5:0]  pkt_seq_o,
  output logic [1:0]  status_o,
  output logic [6:0]  data_count_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]       prefix_q;
  logic             byte_acc;
  logic             q_push;
  kpd_pkg::cmd_t    q_wcmd;
  kpd_pkg::cmd_t    q_rcmd;
  logic             q_pop;
  kpd_pkg::q_stat_t q_stat;
  logic             res_valid;

  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == kpd_pkg::RegCtlPrefix) ? {24'd0, prefix_q} : 32'd0;
  assign full     = q_stat.full;
  assign byte_acc = push && !full;
  assign empty    = !res_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q <= kpd_pkg::PrefixRst;
    end else if (psel && penable && pwrite && paddr[2] == kpd_pkg::RegCtlPrefix) begin
      prefix_q <= pwdata[7:0];
    end
  end

  kpd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (byte_acc),
    .rx_byte_i    (rx_byte_i),
    .ctl_prefix_i (prefix_q),
    .cmd_push_o   (q_push),
    .cmd_o        (q_wcmd)
  );

  kpd_cmd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (q_wcmd),
    .pop_i      (q_pop),
    .pop_cmd_o  (q_rcmd),
    .stat_o     (q_stat)
  );

  kpd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (!q_stat.empty),
    .cmd_i        (q_rcmd),
    .cmd_pop_o    (q_pop),
    .res_pop_i    (pop && !empty),
    .res_valid_o  (res_valid),
    .out_kind_o   (out_kind_o),
    .data_byte_o  (data_byte_o),
    .pkt_type_o   (pkt_type_o),
    .pkt_seq_o    (pkt_seq_o),
    .status_o     (status_o),
    .data_count_o (data_count_o)
  );

  `KPD_ASSERT(a_no_overflow, !(q_push && q_stat.full), "command queue overflow")
  `KPD_ASSERT_IMPL(a_data_count, !empty && out_kind_o == kpd_pkg::KindData, data_count_o != 7'd0, "data result with zero count")
  `KPD_ASSERT_IMPL(a_data_status, !empty && out_kind_o == kpd_pkg::KindData, status_o == kpd_pkg::StGood, "data result with non-zero status")
  `KPD_ASSERT_IMPL(a_summary_data, !empty && out_kind_o == kpd_pkg::KindSummary, data_byte_o == 8'd0, "summary result with data byte set")

endmodule

// ----- tb/sv/tb_kermit_packet_deframer.sv -----
// Self-checking testbench for the packet deframer: directed table, random packets, APB prefix
module tb_kermit_packet_deframer;
  import kpd_pkg::*;

  localparam int HalfPeriod   = 5;
  localparam int ResetCycles  = 6;
  localparam int PhaseItems   = 330;
  localparam int NumPhases    = 6;
  localparam int SettleCycles = 6;
  localparam int DrainLimit   = 500;
  localparam int StallLimit   = 1000;
  localparam int DirLen       = 25;

  localparam logic [2:0] PrefixAddr = {RegCtlPrefix, 2'b00};
  localparam logic [7:0] AsciiD     = 8'd68;
  localparam logic [7:0] AsciiY     = 8'd89;
  localparam logic [7:0] AsciiM     = 8'd77;
  localparam logic [7:0] AsciiA     = 8'd65;

  typedef enum logic [2:0] {
    FR_HUNT,
    FR_LEN,
    FR_SEQ,
    FR_TYPE,
    FR_DATA,
    FR_CHECK,
    FR_SEQ_SHORT,
    FR_TYPE_SHORT
  } frame_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic [7:0] ptype;
    logic [5:0] pseq;
    logic [1:0] status;
    logic [6:0] count;
  } result_t;

  typedef struct packed {
    logic [7:0] rx;
    logic       typed;
    result_t    want;
  } row_t;

  localparam result_t NoWant = '0;

  // Short packet at the field extremes, quoted data packet ending on a prefix,
  // empty packet with a bad check byte, init packet with the prefix passed through.
  localparam row_t DirRows [DirLen] = '{
    '{SohMark, 1'b0, NoWant},
    '{8'd0,    1'b0, NoWant},
    '{8'd0,    1'b0, NoWant},
    '{8'd255,  1'b1, '{KindSummary, 8'd0, 8'd255, 6'd32, StShort, 7'd0}},
    '{SohMark, 1'b0, NoWant},
    '{8'd39,   1'b0, NoWant},
    '{8'd37,   1'b0, NoWant},
    '{AsciiD,  1'b0, NoWant},
    '{PrefixRst, 1'b0, NoWant},
    '{AsciiM,  1'b0, NoWant},
    '{AsciiA,  1'b0, NoWant},
    '{PrefixRst, 1'b0, NoWant},
    '{8'd69,   1'b0, NoWant},
    '{SohMark, 1'b0, NoWant},
    '{LenBase, 1'b0, NoWant},
    '{8'd255,  1'b0, NoWant},
    '{AsciiY,  1'b0, NoWant},
    '{8'd0,    1'b1, '{KindSummary, 8'd0, AsciiY, 6'd31, StBadCheck, 7'd0}},
    '{SohMark, 1'b0, NoWant},
    '{8'd37,   1'b0, NoWant},
    '{CharBase, 1'b0, NoWant},
    '{TypeSinit, 1'b0, NoWant},
    '{PrefixRst, 1'b1, '{KindData, PrefixRst, TypeSinit, 6'd0, StGood, 7'd1}},
    '{8'd255,  1'b1, '{KindData, 8'd255, TypeSinit, 6'd0, StGood, 7'd2}},
    '{8'd92,   1'b0, NoWant}
  };

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        push      = 1'b0;
  logic        full;
  logic [7:0]  rx_byte   = '0;
  logic        empty;
  logic        pop       = 1'b0;
  logic        out_kind;
  logic [7:0]  data_byte;
  logic [7:0]  pkt_type;
  logic [5:0]  pkt_seq;
  logic [1:0]  status;
  logic [6:0]  data_count;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  frame_e     fr_phase   = FR_HUNT;
  logic [7:0] fr_sum     = '0;
  logic [6:0] fr_left    = '0;
  logic [7:0] fr_type    = '0;
  logic [5:0] fr_seq     = '0;
  logic       fr_quote   = 1'b0;
  logic [6:0] fr_count   = '0;
  logic [7:0] prefix_cfg = PrefixRst;

  result_t expect_q [$];
  result_t head;
  int fails = 0;
  int items_done = 0;
  int bytes_sent = 0;
  int results_seen = 0;
  int summaries_seen = 0;
  int prefixes_set = 0;
  int idle_cycles = 0;
  int snd_quiet = 0;
  int rcv_quiet = 0;

  kermit_packet_deframer i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .rx_byte_i    (rx_byte),
    .empty        (empty),
    .pop          (pop),
    .out_kind_o   (out_kind),
    .data_byte_o  (data_byte),
    .pkt_type_o   (pkt_type),
    .pkt_seq_o    (pkt_seq),
    .status_o     (status),
    .data_count_o (data_count),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #HalfPeriod clk_i = ~clk_i;

  function automatic bit deframe_byte(input logic [7:0] b, output result_t r);
    logic [7:0] n;
    logic [7:0] d;
    logic [5:0] chk;
    bit hit;
    hit = 1'b0;
    r = NoWant;
    case (fr_phase)
      FR_LEN: begin
        fr_sum = b;
        if (b < LenBase) begin
          fr_phase = FR_SEQ_SHORT;
        end else begin
          n = b - LenBase;
          if (n > {1'b0, MaxData}) n = {1'b0, MaxData};
          fr_left = n[6:0];
          fr_phase = FR_SEQ;
        end
      end
      FR_SEQ, FR_SEQ_SHORT: begin
        fr_sum = fr_sum + b;
        fr_seq = 6'(b - CharBase);
        fr_phase = (fr_phase == FR_SEQ) ? FR_TYPE : FR_TYPE_SHORT;
      end
      FR_TYPE, FR_TYPE_SHORT: begin
        fr_sum = fr_sum + b;
        fr_type = b;
        fr_quote = 1'b0;
        fr_count = '0;
        if (fr_phase == FR_TYPE_SHORT) begin
          fr_phase = FR_HUNT;
          r = '{KindSummary, 8'd0, fr_type, fr_seq, StShort, 7'd0};
          hit = 1'b1;
        end else begin
          fr_phase = (fr_left != 0) ? FR_DATA : FR_CHECK;
        end
      end
      FR_DATA: begin
        fr_sum = fr_sum + b;
        fr_left = fr_left - 7'd1;
        if (fr_type != TypeSinit && !fr_quote && b == prefix_cfg) begin
          fr_quote = 1'b1;
        end else begin
          d = b;
          if (fr_quote) begin
            fr_quote = 1'b0;
            if (b[6:0] >= QuoteLo && b[6:0] <= QuoteHi) d = b ^ Bit6Mask;
          end
          fr_count = fr_count + 7'd1;
          r = '{KindData, d, fr_type, fr_seq, StGood, fr_count};
          hit = 1'b1;
        end
        if (fr_left == 0) fr_phase = FR_CHECK;
      end
      FR_CHECK: begin
        chk = 6'(fr_sum[5:0] + {4'b0, fr_sum[7:6]});
        fr_phase = FR_HUNT;
        r = '{KindSummary, 8'd0, fr_type, fr_seq,
              (b >= CharBase && (b - CharBase) == {2'b00, chk}) ? StGood : StBadCheck,
              fr_count};
        hit = 1'b1;
      end
      default: begin
        if (b == SohMark) begin
          fr_sum = '0;
          fr_phase = FR_LEN;
        end
      end
    endcase
    return hit;
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input result_t typed_want = '0);
    int gap;
    bit counted;
    bit hit;
    result_t want;
    if (snd_quiet > 0) begin
      snd_quiet--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 6);
      if ($urandom_range(0, 49) == 0) snd_quiet = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    rx_byte <= b;
    do @(posedge clk_i); while (full);
    bytes_sent++;
    counted = (fr_phase != FR_HUNT) || (b == SohMark);
    if (counted) items_done++;
    hit = deframe_byte(b, want);
    if (typed) expect_q.push_back(typed_want);
    else if (hit) expect_q.push_back(want);
  endtask

  task automatic send_packet();
    logic [7:0] len;
    logic [7:0] seq;
    logic [7:0] typ;
    logic [7:0] b;
    logic [7:0] sum;
    logic [5:0] chk;
    int n;
    typ = ($urandom_range(0, 5) == 0) ? TypeSinit : 8'($urandom_range(0, 255));
    case ($urandom_range(0, 19))
      0, 1: len = 8'($urandom_range(0, 34));
      2: len = 8'($urandom_range(130, 255));
      3: len = 8'($urandom_range(35, 129));
      default: len = 8'($urandom_range(35, 47));
    endcase
    seq = 8'($urandom_range(0, 255));
    send_byte(SohMark);
    send_byte(len);
    send_byte(seq);
    send_byte(typ);
    if (len < LenBase) return;
    n = int'(len) - int'(LenBase);
    if (n > int'(MaxData)) n = int'(MaxData);
    sum = len + seq + typ;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0, 1: b = prefix_cfg;
        2: b = {1'($urandom_range(0, 1)), 7'($urandom_range(63, 95))};
        3: b = SohMark;
        default: b = 8'($urandom_range(0, 255));
      endcase
      sum = sum + b;
      send_byte(b);
    end
    chk = 6'(sum[5:0] + {4'b0, sum[7:6]});
    if ($urandom_range(0, 9) == 0) b = 8'($urandom_range(0, 255));
    else b = {2'b00, chk} + CharBase;
    send_byte(b);
  endtask

  task automatic drain_results();
    int waited;
    push <= 1'b0;
    waited = 0;
    while (expect_q.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    if (expect_q.size() != 0) begin
      $error("%0d expected results never arrived", expect_q.size());
      fails++;
      expect_q.delete();
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apb_access(input bit wr, input logic [7:0] val, output logic [31:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= PrefixAddr;
    pwdata  <= {24'b0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_prefix_reg();
    logic [31:0] rd;
    apb_access(1'b0, 8'd0, rd);
    if (rd[7:0] !== prefix_cfg) begin
      $error("ctl_prefix: expected %0d, got %0d", prefix_cfg, rd[7:0]);
      fails++;
    end
  endtask

  task automatic set_prefix(input logic [7:0] val);
    logic [31:0] rd;
    while (fr_phase != FR_HUNT) send_byte(8'($urandom_range(0, 255)));
    drain_results();
    apb_access(1'b1, val, rd);
    prefix_cfg = val;
    prefixes_set++;
    check_prefix_reg();
  endtask

  initial begin
    logic [7:0] val;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_prefix_reg();
    for (int i = 0; i < DirLen; i++) begin
      send_byte(DirRows[i].rx, DirRows[i].typed, DirRows[i].want);
    end
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: val = PrefixRst;
        1: val = 8'd0;
        2: val = 8'd255;
        3: val = SohMark;
        4: val = 8'($urandom_range(0, 255));
        default: val = PrefixRst;
      endcase
      if (p > 0) set_prefix(val);
      while (items_done < (p + 1) * PhaseItems) begin
        case ($urandom_range(0, 9))
          0: repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)));
          1: begin
            send_byte(SohMark);
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
          end
          default: send_packet();
        endcase
        if ($urandom_range(0, 49) == 0) drain_results();
      end
    end
    while (fr_phase != FR_HUNT) send_byte(8'($urandom_range(0, 255)));
    drain_results();
    $display("Sent %0d bytes over %0d prefix settings; checked %0d results (%0d summaries).",
             bytes_sent, prefixes_set + 1, results_seen, summaries_seen);
    $display("Covered short, empty, long, init and quoted packets, bad checks and noise.");
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    int gap;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (rcv_quiet > 0) begin
        rcv_quiet--;
        gap = 0;
      end else begin
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 49) == 0) rcv_quiet = $urandom_range(10, 40);
      end
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      results_seen++;
      if (out_kind === KindSummary) summaries_seen++;
      if (expect_q.size() == 0) begin
        $error("unexpected result: kind %0d data %0d", out_kind, data_byte);
        fails++;
      end else begin
        head = expect_q.pop_front();
        if (out_kind !== head.kind) begin
          $error("out_kind: expected %0d, got %0d", head.kind, out_kind);
          fails++;
        end
        if (data_byte !== head.data) begin
          $error("data_byte: expected %0d, got %0d", head.data, data_byte);
          fails++;
        end
        if (pkt_type !== head.ptype) begin
          $error("pkt_type: expected %0d, got %0d", head.ptype, pkt_type);
          fails++;
        end
        if (pkt_seq !== head.pseq) begin
          $error("pkt_seq: expected %0d, got %0d", head.pseq, pkt_seq);
          fails++;
        end
        if (status !== head.status) begin
          $error("status: expected %0d, got %0d", head.status, status);
          fails++;
        end
        if (data_count !== head.count) begin
          $error("data_count: expected %0d, got %0d", head.count, data_count);
          fails++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule
